// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the checker file of this block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on the rising clock edge, off while in reset
`define SMVC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Concurrent assertion that also holds during reset
`define SMVC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

// ===== rtl/smvc_pkg.sv =====
// ----------------------------------------------------------------------------
// smvc_pkg
// Types and constants shared by the sign-magnitude varint codec modules.
// ----------------------------------------------------------------------------
`default_nettype none

package smvc_pkg;

   // default word width of the codec
   localparam int WORD_BITS_DEF = 64;

   // stream widths
   localparam int REQ_TDATA_BITS = 72;
   localparam int RSP_TDATA_BITS = 72;
   localparam int RSP_TUSER_BITS = 2;
   localparam int CSR_INDEX_BITS = 2;

   // byte format
   localparam logic [7:0] CONT_BIT = 8'h80;
   localparam logic [7:0] SIGN_BIT = 8'h40;
   localparam logic [7:0] LOW6     = 8'h3f;
   localparam logic [7:0] LOW7     = 8'h7f;

   // run bookkeeping
   localparam logic [6:0] MAX_POS   = 7'd70;
   localparam logic [6:0] POS_STEP  = 7'd7;
   localparam logic [3:0] MAX_CONT  = 4'd9;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIRECTION   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SIGNED_MODE = 2'd1;

   // shared unit operations
   typedef enum logic [1:0] {
      OP_NEG,
      OP_SHR7,
      OP_INSERT
   } alu_op_type;

   // control for the shared unit
   typedef struct packed {
      alu_op_type op;
      logic [6:0] grp;
      logic [6:0] pos;
   } alu_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/smvc_alu.sv =====
// ----------------------------------------------------------------------------
// smvc_alu
// Shared word unit: negate, shift right by one group, or insert a group.
// ----------------------------------------------------------------------------
`default_nettype none

module smvc_alu
   import smvc_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  wire alu_ctl_type          ctl,
   input  wire logic [WORD_BITS-1:0] operand,
   output logic      [WORD_BITS-1:0] result
);

   logic [WORD_BITS-1:0] grp_ext;
   logic [WORD_BITS-1:0] grp_shifted;

   // place the group at its bit position; positions past the word add nothing
   always_comb begin
      grp_ext = WORD_BITS'(ctl.grp);
      if (32'(ctl.pos) < WORD_BITS) begin
         grp_shifted = grp_ext << ctl.pos;
      end else begin
         grp_shifted = '0;
      end
   end

   // select the operation
   always_comb begin
      unique case (ctl.op)
         OP_NEG:    result = '0 - operand;
         OP_SHR7:   result = operand >> 7;
         OP_INSERT: result = operand + grp_shifted;
         default:   result = operand;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/sign_magnitude_varint_codec.sv =====
// ----------------------------------------------------------------------------
// sign_magnitude_varint_codec
// Sign-magnitude 7-bit varint encoder and decoder around one shared word unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word in: in_word for encode, in_byte for decode.
//   rsp_* carries results: encoded bytes with tlast on the final byte of a
//   run, or decoded words with the sign_dropped and too_long flags in tuser.
//   csr_* writes direction (index 0) and signed_mode (index 1); a write to either
//   abandons a partial decode run. Write registers only while idle.
// Timing:
//   Decode: each byte is taken on its own handshake. A final byte moves to
//   S_DOUT, or first to S_DNEG when a signed negative value needs the negate
//   pass through the shared unit. req_tready stays low until the word is taken.
//   Encode: the word is taken with negation done on entry; then one byte per
//   cycle while rsp_tready is high, each shift by 7 going through the shared unit.
//   Backpressure on rsp holds the current result stable and stalls req.
// Reset: direction = encode, signed_mode = 1, decode run state cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sign_magnitude_varint_codec
   import smvc_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  wire  logic                      clock,
   input  wire  logic                      reset,
   // request stream: [63:0] in_word, [71:64] in_byte
   input  wire  logic                      req_tvalid,
   output logic                            req_tready,
   input  wire  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // response stream: [7:0] out_byte, [71:8] out_word
   output logic                            rsp_tvalid,
   input  wire  logic                      rsp_tready,
   output logic       [RSP_TDATA_BITS-1:0] rsp_tdata,
   // response flags: [0] sign_dropped, [1] too_long
   output logic       [RSP_TUSER_BITS-1:0] rsp_tuser,
   output logic                            rsp_tlast,
   // register write channel
   input  wire  logic                      csr_valid,
   output logic                            csr_ready,
   input  wire  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire  logic                      csr_data
);

   localparam logic [WORD_BITS-1:0] TOP_BIT   = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [WORD_BITS-1:0] TOP_MAG   = TOP_BIT >> 7;
   localparam logic [WORD_BITS-1:0] MAG_LIMIT = WORD_BITS'(LOW6);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EMIT,
      S_DNEG,
      S_DOUT
   } state_type;

   state_type            state_ff,  state_in;
   logic                 dir_ff,    dir_in;
   logic                 sgn_ff,    sgn_in;
   logic [WORD_BITS-1:0] acc_ff,    acc_in;
   logic [6:0]           pos_ff,    pos_in;
   logic                 ovl_ff,    ovl_in;
   logic                 neg_ff,    neg_in;
   logic                 lead_ff,   lead_in;
   logic [3:0]           cnt_ff,    cnt_in;
   logic                 dsign_ff,  dsign_in;

   alu_ctl_type          alu_ctl;
   logic [WORD_BITS-1:0] alu_operand;
   logic [WORD_BITS-1:0] alu_result;

   logic                 req_fire;
   logic                 rsp_fire;
   logic                 csr_fire;
   logic [WORD_BITS-1:0] in_word;
   logic [7:0]           in_byte;
   logic                 enc_cont;
   logic [7:0]           enc_byte;

   smvc_alu #(
      .WORD_BITS(WORD_BITS)
   ) u_alu (
      .ctl    (alu_ctl),
      .operand(alu_operand),
      .result (alu_result)
   );

   // handshakes
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_EMIT) || (state_ff == S_DOUT);
   assign csr_ready  = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign csr_fire   = csr_valid && csr_ready;

   assign in_word = req_tdata[WORD_BITS-1:0];
   assign in_byte = req_tdata[71:64];

   // form the current encoded byte from the held magnitude
   always_comb begin
      enc_cont = (acc_ff > MAG_LIMIT) && (cnt_ff < MAX_CONT);
      if (lead_ff) begin
         enc_byte = CONT_BIT;
      end else if (enc_cont) begin
         enc_byte = CONT_BIT | {1'b0, acc_ff[6:0]};
      end else begin
         enc_byte = {1'b0, acc_ff[6:0]} | (neg_ff ? SIGN_BIT : 8'h00);
      end
   end

   // drive the response word
   always_comb begin
      rsp_tdata = '0;
      rsp_tuser = '0;
      rsp_tlast = 1'b0;
      unique case (state_ff)
         S_EMIT: begin
            rsp_tdata = {64'h0, enc_byte};
            rsp_tlast = !lead_ff && !enc_cont;
         end
         S_DOUT: begin
            rsp_tdata = {64'(acc_ff), 8'h00};
            rsp_tuser = {ovl_ff, !sgn_ff && dsign_ff};
         end
         default: begin
            rsp_tdata = '0;
         end
      endcase
   end

   // sequence the shared unit and compute next register values
   always_comb begin
      state_in    = state_ff;
      dir_in      = dir_ff;
      sgn_in      = sgn_ff;
      acc_in      = acc_ff;
      pos_in      = pos_ff;
      ovl_in      = ovl_ff;
      neg_in      = neg_ff;
      lead_in     = lead_ff;
      cnt_in      = cnt_ff;
      dsign_in    = dsign_ff;
      alu_ctl     = '{op: OP_SHR7, grp: 7'd0, pos: 7'd0};
      alu_operand = acc_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && !dir_ff) begin
               // encode: load the magnitude, negating on entry
               neg_in   = sgn_ff && in_word[WORD_BITS-1];
               cnt_in   = '0;
               lead_in  = 1'b0;
               state_in = S_EMIT;
               if (sgn_ff && (in_word == TOP_BIT)) begin
                  lead_in = 1'b1;
                  acc_in  = TOP_MAG;
               end else if (sgn_ff && in_word[WORD_BITS-1]) begin
                  alu_ctl.op  = OP_NEG;
                  alu_operand = in_word;
                  acc_in      = alu_result;
               end else begin
                  acc_in = in_word;
               end
            end else if (req_fire) begin
               // decode: add the group at the current position, or set the overflow flag at the position limit
               alu_ctl.op  = OP_INSERT;
               alu_ctl.pos = pos_ff;
               alu_ctl.grp = in_byte[7] ? in_byte[6:0] : (in_byte[6:0] & LOW6[6:0]);
               if (pos_ff >= MAX_POS) begin
                  ovl_in = 1'b1;
               end else begin
                  acc_in = alu_result;
                  if (in_byte[7]) begin
                     pos_in = pos_ff + POS_STEP;
                  end
               end
               if (!in_byte[7]) begin
                  dsign_in = in_byte[6];
                  state_in = (sgn_ff && in_byte[6]) ? S_DNEG : S_DOUT;
               end
            end
         end
         S_DNEG: begin
            // negate the decoded magnitude
            alu_ctl.op = OP_NEG;
            acc_in     = alu_result;
            state_in   = S_DOUT;
         end
         S_DOUT: begin
            // drop the run once the word is taken
            if (rsp_fire) begin
               acc_in   = '0;
               pos_in   = '0;
               ovl_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            // advance to the next group once the byte is taken, or return to idle after the last
            if (rsp_fire) begin
               if (lead_ff) begin
                  lead_in = 1'b0;
                  cnt_in  = 4'd1;
               end else if (enc_cont) begin
                  alu_ctl.op = OP_SHR7;
                  acc_in     = alu_result;
                  cnt_in     = cnt_ff + 4'd1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes clear the decode run
      if (csr_fire && (csr_index == REG_DIRECTION)) begin
         dir_in = csr_data;
         acc_in = '0;
         pos_in = '0;
         ovl_in = 1'b0;
      end else if (csr_fire && (csr_index == REG_SIGNED_MODE)) begin
         sgn_in = csr_data;
         acc_in = '0;
         pos_in = '0;
         ovl_in = 1'b0;
      end
   end

   // hold state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dir_ff   <= 1'b0;
         sgn_ff   <= 1'b1;
         acc_ff   <= '0;
         pos_ff   <= '0;
         ovl_ff   <= 1'b0;
         lead_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         dir_ff   <= dir_in;
         sgn_ff   <= sgn_in;
         acc_ff   <= acc_in;
         pos_ff   <= pos_in;
         ovl_ff   <= ovl_in;
         lead_ff  <= lead_in;
         cnt_ff   <= cnt_in;
      end
      neg_ff   <= neg_in;
      dsign_ff <= dsign_in;
   end

endmodule

`default_nettype wire

// ===== rtl/smvc_checker.sv =====
// ----------------------------------------------------------------------------
// smvc_checker
// Port-level checks on the varint codec, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module smvc_checker
   import smvc_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input wire logic [RSP_TUSER_BITS-1:0] rsp_tuser,
   input wire logic                      rsp_tlast
);

   // a stalled response word holds its payload
   `SMVC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

   // no new request is taken while a result is pending
   `SMVC_ASSERT(a_busy_excl, clock, reset, !(req_tready && rsp_tvalid))

   // final encoded byte carries no decoded word and no flags
   `SMVC_ASSERT(a_last_clean, clock, reset, rsp_tvalid && rsp_tlast |-> (rsp_tdata[71:8] == 64'h0) && (rsp_tuser == '0))

   // reset leaves no result pending
   `SMVC_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid)

endmodule

bind sign_magnitude_varint_codec smvc_checker u_smvc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);

`default_nettype wire
